// ----- src/sgw_pkg.sv -----
// ----------------------------------------------------------------------------
// sgw_pkg
// Shared types and constants of the Savitzky-Golay weight generator.
// ----------------------------------------------------------------------------
`default_nettype none
package sgw_pkg;
	localparam int WEIGHT_W = 48;
	localparam int STATUS_W = 2;
	localparam int IDX_W    = 6;
	localparam int ORD_W    = 4;
	localparam int HW_W     = 5;
	localparam int CFG_W    = 5;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ORD = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SAT = 2'd2;

	// register indexes
	localparam logic CFG_HALF_WIDTH = 1'b0;
	localparam logic CFG_POLY_ORDER = 1'b1;

	// shared unit operations
	typedef enum logic [2:0] {
		OP_MULI,
		OP_ADD,
		OP_DIV,
		OP_FMUL
	} sgw_op_t;

	typedef struct packed {
		logic    start;
		sgw_op_t op;
	} sgw_ctl_t;

	typedef struct packed {
		logic done;
		logic clip;
	} sgw_sts_t;
endpackage
`default_nettype wire

// ----- src/sgw_if.sv -----
// ----------------------------------------------------------------------------
// sgw_in_if / sgw_out_if
// Valid/ready channels of the weight generator.
// ----------------------------------------------------------------------------
`default_nettype none
interface sgw_in_if;
	logic              valid;
	logic              ready;
	logic signed [5:0] point_index;
	logic signed [5:0] eval_point;
	logic        [3:0] deriv_order;
	modport source (output valid, point_index, eval_point, deriv_order, input ready);
	modport sink (input valid, point_index, eval_point, deriv_order, output ready);
endinterface

interface sgw_out_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] weight;
	logic        [1:0]  status;
	modport source (output valid, weight, status, input ready);
	modport sink (input valid, weight, status, output ready);
endinterface
`default_nettype wire

// ----- src/savitzky_golay_weight.sv -----
// ----------------------------------------------------------------------------
// savitzky_golay_weight
// Savitzky-Golay convolution weight by the Gram-polynomial method.
//
//  channel  | dir | contents
//  in_ch    | in  | point_index, eval_point, deriv_order
//  out_ch   | out | weight, status
//  cfg      | in  | cfg_we, cfg_idx, cfg_data (half_width, poly_order)
//
// One word at a time through the shared unit, which carries every product and
// quotient: a multiply works on 32-bit partials and a divide is bit serial (one
// quotient bit a cycle). The result is set straight from the range check when
// the order exceeds 2m or the derivative exceeds the order; otherwise the Gram
// rows and the weight sum run through the shared unit before the result is set.
// Reset clears control; ready stays low until the result word is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module savitzky_golay_weight
	import sgw_pkg::*;
#(
	parameter int MAX_HALF_WIDTH = 16,
	parameter int MAX_ORDER      = 8,
	parameter int FRAC_BITS      = 40
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	sgw_in_if.sink          in_ch,
	sgw_out_if.source       out_ch,
	input  wire logic       cfg_we,
	input  wire logic       cfg_idx,
	input  wire logic [CFG_W-1:0] cfg_data
);
	localparam int NK = MAX_ORDER + 1;
	localparam int KW = $clog2(NK);
	localparam logic signed [63:0] LIM = 64'sh7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [4:0] {
		S_IDLE, S_CHK, S_G_K0, S_G_T1, S_G_T1W, S_G_J, S_G_JW, S_G_JA, S_G_JAW,
		S_G_T2, S_G_T2W, S_G_T3, S_G_T3W, S_G_SUB, S_G_SUBW, S_G_DIV, S_G_DIVW,
		S_G_NEXT, S_R0, S_R1, S_R1W, S_R2, S_R2W, S_C, S_CW, S_F1, S_F1W, S_F2,
		S_F2W, S_ACC, S_ACCW, S_DONE
	} st_t;

	st_t st_q;
	logic [HW_W-1:0]  hw_q;
	logic [ORD_W-1:0] po_q;
	logic signed [5:0] xi_q, xt_q;
	logic [ORD_W-1:0] s_q, n_q, j_q;
	logic [KW-1:0]    k_q;
	logic [6:0]       m_q;
	logic             pass_q; // 0: data point, 1: evaluation point
	logic             clip_q;
	logic signed [63:0] g_cur_q [NK]; // row j
	logic signed [63:0] g_prv_q [NK]; // row j-1
	logic signed [63:0] pi_q [NK];
	logic signed [63:0] t1_q, t2_q, t3_q, r_q, c_q, f_q, sum_q;
	logic signed [63:0] a, b;
	sgw_ctl_t ctl;
	sgw_sts_t sts;
	logic signed [63:0] y;
	logic signed [47:0] w_q;
	logic [1:0]         st_out_q;
	logic               sum_ovf, sum_unf;

	sgw_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .a(a), .b(b), .sts(sts), .y(y)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= HW_W'(2);
			po_q <= ORD_W'(2);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_HALF_WIDTH: hw_q <= cfg_data[HW_W-1:0];
				CFG_POLY_ORDER: po_q <= cfg_data[ORD_W-1:0];
				default: ;
			endcase
		end
	end

	logic [KW-1:0] km1, km2;
	logic signed [63:0] xv;
	assign km1 = k_q - KW'(1);
	assign km2 = k_q - KW'(2);
	assign xv  = pass_q ? 64'(xt_q) : 64'(xi_q);

	// operand mux for the shared unit
	always_comb begin
		ctl = '{start: 1'b0, op: OP_MULI};
		a = '0;
		b = '0;
		case (st_q)
			S_G_T1: begin ctl = '{1'b1, OP_MULI}; a = g_cur_q[km1]; b = xv; end
			S_G_J:  begin ctl = '{1'b1, OP_MULI}; a = g_prv_q[km1]; b = 64'(j_q); end
			S_G_T2: begin ctl = '{1'b1, OP_MULI}; a = t1_q; b = 64'(k_q) * 64'd4 - 64'd2; end
			S_G_T3: begin
				ctl = '{1'b1, OP_MULI}; a = g_cur_q[km2];
				b = 64'(km1) * (64'(m_q) * 64'd2 + 64'(k_q));
			end
			S_G_DIV: begin
				ctl = '{1'b1, OP_DIV}; a = t2_q;
				b = 64'(k_q) * (64'(m_q) * 64'd2 - 64'(k_q) + 64'd1);
			end
			S_R1: begin
				ctl = '{1'b1, OP_MULI}; a = r_q;
				b = 64'(m_q) * 64'd2 - 64'(k_q) + 64'd1;
			end
			S_R2: begin ctl = '{1'b1, OP_DIV}; a = t1_q; b = 64'(m_q) * 64'd2 + 64'(k_q) + 64'd1; end
			S_R0: begin ctl = '{1'b1, OP_DIV}; a = 64'sd1 <<< FRAC_BITS; b = 64'(m_q) * 64'd2 + 64'd1; end
			S_C:  begin ctl = '{1'b1, OP_MULI}; a = r_q; b = 64'(k_q) * 64'd2 + 64'd1; end
			S_F1: begin ctl = '{1'b1, OP_FMUL}; a = c_q; b = pi_q[k_q[KW-1:0]]; end
			S_F2: begin ctl = '{1'b1, OP_FMUL}; a = f_q; b = g_cur_q[k_q[KW-1:0]]; end
			default: ;
		endcase
	end

	// saturating adds are done here, combinationally, outside the shared unit
	function automatic logic signed [64:0] sat_add(input logic signed [63:0] x,
	                                               input logic signed [63:0] z);
		logic signed [64:0] s;
		s = 65'(x) + 65'(z);
		if (s > 65'(LIM)) return {1'b1, LIM};
		if (s < -65'(LIM)) return {1'b1, -LIM};
		return {1'b0, s[63:0]};
	endfunction

	logic signed [64:0] add_r;
	always_comb begin
		case (st_q)
			S_G_JA:  add_r = sat_add(t1_q, t3_q);
			S_G_SUB: add_r = sat_add(t2_q, (t3_q == -LIM - 64'sd1) ? LIM : -t3_q);
			default: add_r = sat_add(sum_q, f_q);
		endcase
	end

	// final sum against the 48-bit weight range
	assign sum_ovf = sum_q > 64'sh0000_7FFF_FFFF_FFFF;
	assign sum_unf = sum_q < -64'sh0000_8000_0000_0000;

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			in_ch.ready  <= 1'b1;
			out_ch.valid <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						xi_q <= in_ch.point_index;
						xt_q <= in_ch.eval_point;
						s_q  <= in_ch.deriv_order;
						m_q  <= (7'(hw_q) > 7'(MAX_HALF_WIDTH)) ? 7'(MAX_HALF_WIDTH) : 7'(hw_q);
						n_q  <= (5'(po_q) > 5'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : po_q;
						in_ch.ready <= 1'b0;
						clip_q <= 1'b0;
						st_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (7'(n_q) > m_q * 7'd2) begin
						w_q <= '0; st_out_q <= ST_ORD; st_q <= S_DONE;
						out_ch.valid <= 1'b1;
					end else if (s_q > n_q) begin
						w_q <= '0; st_out_q <= ST_OK; st_q <= S_DONE;
						out_ch.valid <= 1'b1;
					end else begin
						pass_q <= 1'b0; j_q <= '0; st_q <= S_G_K0;
					end
				end
				// start of row j: g[j][0]
				S_G_K0: begin
					for (int i = 0; i < NK; i++) g_prv_q[i] <= g_cur_q[i];
					g_cur_q[0] <= (j_q == '0) ? (64'sd1 <<< FRAC_BITS) : 64'sd0;
					k_q <= KW'(1);
					st_q <= (n_q == '0) ? S_G_NEXT : S_G_T1;
				end
				S_G_T1: st_q <= S_G_T1W;
				S_G_T1W: if (sts.done) begin
					t1_q <= y; clip_q <= clip_q | sts.clip;
					st_q <= (j_q != '0) ? S_G_J : S_G_T2;
				end
				S_G_J: st_q <= S_G_JW;
				S_G_JW: if (sts.done) begin
					t3_q <= y; clip_q <= clip_q | sts.clip; st_q <= S_G_JA;
				end
				S_G_JA: begin
					t1_q <= add_r[63:0]; clip_q <= clip_q | add_r[64]; st_q <= S_G_T2;
				end
				S_G_T2: st_q <= S_G_T2W;
				S_G_T2W: if (sts.done) begin
					t2_q <= y; clip_q <= clip_q | sts.clip;
					if (k_q != KW'(1)) st_q <= S_G_T3;
					else begin t3_q <= '0; st_q <= S_G_SUB; end
				end
				S_G_T3: st_q <= S_G_T3W;
				S_G_T3W: if (sts.done) begin
					t3_q <= y; clip_q <= clip_q | sts.clip; st_q <= S_G_SUB;
				end
				S_G_SUB: begin
					t2_q <= add_r[63:0]; clip_q <= clip_q | add_r[64]; st_q <= S_G_DIV;
				end
				S_G_DIV: st_q <= S_G_DIVW;
				S_G_DIVW: if (sts.done) begin
					g_cur_q[k_q[KW-1:0]] <= y; clip_q <= clip_q | sts.clip;
					if (k_q == KW'(n_q)) st_q <= S_G_NEXT;
					else begin k_q <= k_q + KW'(1); st_q <= S_G_T1; end
				end
				S_G_NEXT: begin
					if (pass_q ? (j_q == s_q) : 1'b1) begin
						if (!pass_q) begin
							for (int i = 0; i < NK; i++) pi_q[i] <= g_cur_q[i];
							pass_q <= 1'b1; j_q <= '0; st_q <= S_G_K0;
						end else begin
							k_q <= '0; sum_q <= '0; st_q <= S_R0;
						end
					end else begin
						j_q <= j_q + ORD_W'(1); st_q <= S_G_K0;
					end
				end
				// weight sum over k
				S_R0: st_q <= S_R2W;
				S_R1: st_q <= S_R1W;
				S_R1W: if (sts.done) begin
					t1_q <= y; clip_q <= clip_q | sts.clip; st_q <= S_R2;
				end
				S_R2: st_q <= S_R2W;
				S_R2W: if (sts.done) begin
					r_q <= y; clip_q <= clip_q | sts.clip; st_q <= S_C;
				end
				S_C: st_q <= S_CW;
				S_CW: if (sts.done) begin
					c_q <= y; clip_q <= clip_q | sts.clip; st_q <= S_F1;
				end
				S_F1: st_q <= S_F1W;
				S_F1W: if (sts.done) begin
					f_q <= y; clip_q <= clip_q | sts.clip; st_q <= S_F2;
				end
				S_F2: st_q <= S_F2W;
				S_F2W: if (sts.done) begin
					f_q <= y; clip_q <= clip_q | sts.clip; st_q <= S_ACC;
				end
				S_ACC: begin
					sum_q <= add_r[63:0]; clip_q <= clip_q | add_r[64];
					if (k_q == KW'(n_q)) st_q <= S_ACCW;
					else begin k_q <= k_q + KW'(1); st_q <= S_R1; end
				end
				S_ACCW: begin
					if (sum_ovf) w_q <= 48'sh7FFF_FFFF_FFFF;
					else if (sum_unf) w_q <= 48'sh8000_0000_0000;
					else w_q <= sum_q[47:0];
					st_out_q <= (clip_q | sum_ovf | sum_unf) ? ST_SAT : ST_OK;
					out_ch.valid <= 1'b1;
					st_q <= S_DONE;
				end
				S_DONE: begin
					if (out_ch.ready) begin
						out_ch.valid <= 1'b0;
						in_ch.ready  <= 1'b1;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.weight = w_q;
	assign out_ch.status = st_out_q;
endmodule
`default_nettype wire

// ----- src/sgw_alu.sv -----
// ----------------------------------------------------------------------------
// sgw_alu
// Shared saturating unit: integer multiply, rounded divide by a small
// positive integer (bit serial) and fixed-point multiply (32-bit partials).
// ----------------------------------------------------------------------------
`default_nettype none
module sgw_alu
	import sgw_pkg::*;
#(
	parameter int FRAC_BITS = 40
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sgw_ctl_t           ctl,
	input  wire logic signed [63:0] a,
	input  wire logic signed [63:0] b,
	output sgw_sts_t                sts,
	output logic signed [63:0]      y
);
	localparam logic [63:0] LIM = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_OUT} st_t;

	st_t          st_q;
	logic [63:0]  ua_q, ub_q;
	logic         neg_q;
	logic [127:0] acc_q;
	logic [1:0]   part_q;
	logic [6:0]   cnt_q;
	logic [64:0]  rem_q;
	logic [64:0]  quo_q;
	sgw_op_t      op_q;

	logic [63:0] ua, ub;
	logic [31:0] pa, pb;
	logic [63:0] pp;
	logic [127:0] pp_sh;
	logic [64:0] rem_n;
	logic [128:0] rnd;
	logic [64:0] mag_res;
	logic        ovf;

	assign ua = a[63] ? 64'(-a) : 64'(a);
	assign ub = b[63] ? 64'(-b) : 64'(b);

	// partial-product select
	always_comb begin
		pa = part_q[0] ? ua_q[63:32] : ua_q[31:0];
		pb = part_q[1] ? ub_q[63:32] : ub_q[31:0];
		pp = 64'(pa) * 64'(pb);
		pp_sh = 128'(pp) << (7'(part_q[0]) * 7'd32 + 7'(part_q[1]) * 7'd32);
		rem_n = {rem_q[63:0], quo_q[64]};
	end

	// unit sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			sts  <= '0;
		end else begin
			sts.done <= (st_q == S_OUT);
			unique case (st_q)
				S_IDLE: begin
					if (ctl.start) begin
						op_q   <= ctl.op;
						ua_q   <= ua;
						ub_q   <= ub;
						neg_q  <= (ctl.op == OP_DIV) ? a[63] : a[63] ^ b[63];
						acc_q  <= '0;
						part_q <= '0;
						cnt_q  <= '0;
						unique case (ctl.op)
							OP_DIV: begin
								// dividend magnitude plus half the divisor
								quo_q <= 65'(ua) + 65'(b[63:1]);
								rem_q <= '0;
								st_q  <= S_DIV;
							end
							default: st_q <= S_MUL;
						endcase
					end
				end
				S_MUL: begin
					acc_q  <= acc_q + pp_sh;
					part_q <= part_q + 2'd1;
					if (part_q == 2'd3) st_q <= S_OUT;
				end
				S_DIV: begin
					if (rem_n >= {1'b0, ub_q}) begin
						rem_q <= rem_n - {1'b0, ub_q};
						quo_q <= {quo_q[63:0], 1'b1};
					end else begin
						rem_q <= rem_n;
						quo_q <= {quo_q[63:0], 1'b0};
					end
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd64) st_q <= S_OUT;
				end
				S_OUT: begin
					y        <= neg_q ? -$signed(mag_res[63:0]) : $signed(mag_res[63:0]);
					sts.clip <= ovf;
					st_q     <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign rnd   = {1'b0, acc_q} + (129'(1) << (FRAC_BITS - 1));

	// result magnitude and overflow per operation
	always_comb begin
		mag_res = '0;
		ovf     = 1'b0;
		case (op_q)
			OP_MULI: begin
				if (acc_q[127:64] != '0 || acc_q[63:0] > LIM) begin
					ovf = 1'b1; mag_res = {1'b0, LIM};
				end else mag_res = {1'b0, acc_q[63:0]};
			end
			OP_FMUL: begin
				if ((rnd[127:64] >> FRAC_BITS) != '0) begin
					ovf = 1'b1; mag_res = {1'b0, LIM};
				end else begin
					mag_res = 65'(rnd[127:0] >> FRAC_BITS);
					if (mag_res > {1'b0, LIM}) begin
						ovf = 1'b1; mag_res = {1'b0, LIM};
					end
				end
			end
			OP_DIV: begin
				if (quo_q[63:0] > LIM) begin
					ovf = 1'b1; mag_res = {1'b0, LIM};
				end else mag_res = {1'b0, quo_q[63:0]};
			end
			default: mag_res = '0;
		endcase
	end
endmodule
`default_nettype wire

// ----- src/sgw_checker.sv -----
// ----------------------------------------------------------------------------
// sgw_checker
// Port-level checks of the weight generator.
// ----------------------------------------------------------------------------
`default_nettype none
module sgw_checker
	import sgw_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  status,
	input wire logic [47:0] weight
);
	// one word in flight at a time
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	// status code in range
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_SAT) else $error("bad status");
	// order fault gives zero weight
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_ORD) |-> weight == '0) else $error("nonzero weight");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(weight)) else $error("drop");
endmodule

bind savitzky_golay_weight sgw_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .status(out_ch.status),
	.weight(out_ch.weight)
);
`default_nettype wire
